### rtl/core/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types and constants of the Intel HEX line parser: character
// classes, the token passed from the front end to the back end, and sizes.
// ----------------------------------------------------------------------------
package ihex_pkg;

    // Default limit on the number of bytes decoded from one line.
    localparam int MAX_LINE_BYTES_DEF = 261;

    // Byte index width; the line limit must not exceed 511, which the code does not enforce.
    localparam int IDX_W = 9;

    // Depth of the token queue between front and back end.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Record types.
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_ELA  = 8'h04;

    // Result kinds carried on tuser.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Class of one received character.
    typedef enum logic [2:0] {
        TOK_EOL,
        TOK_COLON,
        TOK_NUL,
        TOK_HEX,
        TOK_OTHER
    } t_tok_kind;

    // Classified character as it travels through the queue.
    typedef struct packed {
        t_tok_kind  kind;
        logic [3:0] nib;
    } t_tok;

    // Queue status seen by the top level.
    typedef struct packed {
        logic               full;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

endpackage

### rtl/core/ihex_front.sv
// ----------------------------------------------------------------------------
// ihex_front
// Accepts characters from the input stream, classifies them and holds the
// resulting token in one register until the queue takes it.
// ----------------------------------------------------------------------------
module ihex_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_char,
    output logic            o_ready,
    output logic            o_tok_valid,
    output ihex_pkg::t_tok  o_tok,
    input  logic            i_tok_ready
);

    logic           r_valid;
    ihex_pkg::t_tok r_tok;
    ihex_pkg::t_tok n_tok;

    // Classification of the incoming character.
    always_comb begin
        n_tok.nib  = 4'h0;
        n_tok.kind = ihex_pkg::TOK_OTHER;
        if (i_char == ihex_pkg::CH_CR || i_char == ihex_pkg::CH_LF) begin
            n_tok.kind = ihex_pkg::TOK_EOL;
        end else if (i_char == ihex_pkg::CH_COLON) begin
            n_tok.kind = ihex_pkg::TOK_COLON;
        end else if (i_char == ihex_pkg::CH_NUL) begin
            n_tok.kind = ihex_pkg::TOK_NUL;
        end else if (i_char inside {[8'h30:8'h39]}) begin
            n_tok.kind = ihex_pkg::TOK_HEX;
            n_tok.nib  = i_char[3:0];
        end else if (i_char inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            n_tok.kind = ihex_pkg::TOK_HEX;
            n_tok.nib  = i_char[3:0] + 4'd9;
        end
    end

    // The stage takes a new character whenever it is empty or being emptied.
    assign o_ready     = !r_valid || i_tok_ready;
    assign o_tok_valid = r_valid;
    assign o_tok       = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_tok <= n_tok;
        end
    end

endmodule

### rtl/core/ihex_queue.sv
// ----------------------------------------------------------------------------
// ihex_queue
// Short token queue that decouples the front end from the back end; a push
// and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module ihex_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ihex_pkg::t_tok    i_tok,
    output logic              o_push_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output ihex_pkg::t_tok    o_tok,
    output ihex_pkg::t_q_stat o_stat
);

    ihex_pkg::t_tok                   r_mem [ihex_pkg::Q_DEPTH];
    logic [ihex_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [ihex_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [ihex_pkg::Q_CNT_W-1:0]     r_count;
    logic                             w_push;
    logic                             w_pop;

    assign o_push_ready = (r_count != ihex_pkg::Q_CNT_W'(ihex_pkg::Q_DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_tok        = r_mem[r_rd_ptr];
    assign o_stat.full  = !o_push_ready;
    assign o_stat.count = r_count;

    assign w_push = i_push && o_push_ready;
    assign w_pop  = i_pop && o_valid;

    // Pointers wrap at the queue depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == ihex_pkg::Q_PTR_W'(ihex_pkg::Q_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == ihex_pkg::Q_PTR_W'(ihex_pkg::Q_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage of the queued tokens.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

endmodule

### rtl/core/ihex_back.sv
// ----------------------------------------------------------------------------
// ihex_back
// Carries out the record decode for each token: byte assembly, running sum,
// record fields, fill level, and the registered result towards the output.
// ----------------------------------------------------------------------------
module ihex_back #(
    parameter int MAX_LINE_BYTES = ihex_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tok_valid,
    input  ihex_pkg::t_tok  i_tok,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_kind,
    output logic [7:0]      o_data_byte,
    output logic [15:0]     o_position,
    output logic            o_line_ok,
    output logic [7:0]      o_record_type,
    output logic [7:0]      o_byte_count,
    output logic [15:0]     o_load_address,
    output logic [15:0]     o_fill_level
);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_DECODE,
        PH_STOP
    } t_phase;

    localparam logic [ihex_pkg::IDX_W-1:0] IDX_LIMIT = ihex_pkg::IDX_W'(MAX_LINE_BYTES);

    t_phase                       r_phase,  n_phase;
    logic                         r_pend,   n_pend;
    logic [3:0]                   r_hi,     n_hi;
    logic [ihex_pkg::IDX_W-1:0]   r_idx,    n_idx;
    logic [7:0]                   r_sum,    n_sum;
    logic [7:0]                   r_cnt,    n_cnt;
    logic [15:0]                  r_addr,   n_addr;
    logic [7:0]                   r_type,   n_type;
    logic [15:0]                  r_fill,   n_fill;

    logic                         r_ovalid, n_ovalid;
    logic                         r_kind,   n_kind;
    logic [7:0]                   r_odata,  n_odata;
    logic [15:0]                  r_opos,   n_opos;
    logic                         r_ook,    n_ook;
    logic [7:0]                   r_otype,  n_otype;
    logic [7:0]                   r_ocnt,   n_ocnt;
    logic [15:0]                  r_oaddr,  n_oaddr;
    logic [15:0]                  r_ofill,  n_ofill;

    logic                         w_pop;
    logic [7:0]                   w_byte;
    logic [ihex_pkg::IDX_W-1:0]   w_pay_idx;
    logic                         w_ok;

    // A token is taken whenever the output register is free or being drained.
    assign w_pop     = i_tok_valid && (!r_ovalid || i_ready);
    assign o_pop     = w_pop;
    assign w_byte    = {r_hi, i_tok.nib};
    assign w_pay_idx = r_idx - ihex_pkg::IDX_W'(4);
    assign w_ok      = (r_idx != '0) && (r_sum == 8'h00);

    // Next state and next result.
    always_comb begin
        n_phase  = r_phase;
        n_pend   = r_pend;
        n_hi     = r_hi;
        n_idx    = r_idx;
        n_sum    = r_sum;
        n_cnt    = r_cnt;
        n_addr   = r_addr;
        n_type   = r_type;
        n_fill   = r_fill;
        n_ovalid = r_ovalid && !i_ready;
        n_kind   = r_kind;
        n_odata  = r_odata;
        n_opos   = r_opos;
        n_ook    = r_ook;
        n_otype  = r_otype;
        n_ocnt   = r_ocnt;
        n_oaddr  = r_oaddr;
        n_ofill  = r_ofill;

        if (w_pop) begin
            n_ovalid = 1'b0;
            n_kind   = ihex_pkg::KIND_DATA;
            n_odata  = 8'h00;
            n_opos   = 16'h0000;
            n_ook    = 1'b0;
            n_otype  = 8'h00;
            n_ocnt   = 8'h00;
            n_oaddr  = 16'h0000;
            n_ofill  = 16'h0000;

            if (i_tok.kind == ihex_pkg::TOK_EOL) begin
                // End of line: report the record and update the fill level.
                if (w_ok) begin
                    if (r_type == ihex_pkg::REC_DATA) begin
                        n_fill = r_fill + {8'h00, r_cnt};
                    end else if (r_type == ihex_pkg::REC_ELA) begin
                        n_fill = 16'h0000;
                    end
                    n_ook   = 1'b1;
                    n_otype = r_type;
                    n_ocnt  = r_cnt;
                    n_oaddr = r_addr;
                end
                n_ovalid = 1'b1;
                n_kind   = ihex_pkg::KIND_END;
                n_ofill  = n_fill;
                n_phase  = PH_WAIT;
                n_pend   = 1'b0;
                n_hi     = 4'h0;
                n_idx    = '0;
                n_sum    = 8'h00;
                n_cnt    = 8'h00;
                n_addr   = 16'h0000;
                n_type   = 8'h00;
            end else begin
                case (r_phase)
                    PH_WAIT: begin
                        if (i_tok.kind == ihex_pkg::TOK_COLON) begin
                            n_phase = PH_DECODE;
                        end else if (i_tok.kind == ihex_pkg::TOK_NUL) begin
                            n_phase = PH_STOP;
                        end
                    end
                    PH_DECODE: begin
                        if (i_tok.kind != ihex_pkg::TOK_HEX) begin
                            n_phase = PH_STOP;
                            n_pend  = 1'b0;
                        end else if (!r_pend) begin
                            n_hi   = i_tok.nib;
                            n_pend = 1'b1;
                        end else begin
                            // Second digit completes a byte.
                            n_pend = 1'b0;
                            n_sum  = r_sum + w_byte;
                            n_idx  = r_idx + 1'b1;
                            if (n_idx >= IDX_LIMIT) begin
                                n_phase = PH_STOP;
                            end
                            if (r_idx == ihex_pkg::IDX_W'(0)) begin
                                n_cnt = w_byte;
                            end else if (r_idx == ihex_pkg::IDX_W'(1)) begin
                                n_addr[15:8] = w_byte;
                            end else if (r_idx == ihex_pkg::IDX_W'(2)) begin
                                n_addr[7:0] = w_byte;
                            end else if (r_idx == ihex_pkg::IDX_W'(3)) begin
                                n_type = w_byte;
                            end else if (w_pay_idx < {1'b0, r_cnt}) begin
                                n_ovalid = 1'b1;
                                n_kind   = ihex_pkg::KIND_DATA;
                                n_odata  = w_byte;
                                n_opos   = r_fill + {7'd0, w_pay_idx};
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Line state, fill level and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT;
            r_pend   <= 1'b0;
            r_hi     <= 4'h0;
            r_idx    <= '0;
            r_sum    <= 8'h00;
            r_cnt    <= 8'h00;
            r_addr   <= 16'h0000;
            r_type   <= 8'h00;
            r_fill   <= 16'h0000;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_pend   <= n_pend;
            r_hi     <= n_hi;
            r_idx    <= n_idx;
            r_sum    <= n_sum;
            r_cnt    <= n_cnt;
            r_addr   <= n_addr;
            r_type   <= n_type;
            r_fill   <= n_fill;
            r_ovalid <= n_ovalid;
        end
        r_kind  <= n_kind;
        r_odata <= n_odata;
        r_opos  <= n_opos;
        r_ook   <= n_ook;
        r_otype <= n_otype;
        r_ocnt  <= n_ocnt;
        r_oaddr <= n_oaddr;
        r_ofill <= n_ofill;
    end

    assign o_valid        = r_ovalid;
    assign o_kind         = r_kind;
    assign o_data_byte    = r_odata;
    assign o_position     = r_opos;
    assign o_line_ok      = r_ook;
    assign o_record_type  = r_otype;
    assign o_byte_count   = r_ocnt;
    assign o_load_address = r_oaddr;
    assign o_fill_level   = r_ofill;

endmodule

### rtl/core/intel_hex_line_parser_top.sv
// ----------------------------------------------------------------------------
// intel_hex_line_parser_top
// Intel HEX record line parser: one ASCII character per transfer in, data
// bytes and record-end reports out.
// ----------------------------------------------------------------------------
// The parser takes one character per clock cycle while the output is not
// stalled and gives at most one result per character. A character passes a
// classification register, a two-entry token queue and the decode register;
// the decode step holds the only loop (running sum and fill level), which
// sets the sustained rate of one character per cycle. tuser 0 marks a
// tentative payload byte with its buffer position; tuser 1 marks the end of a
// line with the checksum verdict, the record fields and the fill level.
module intel_hex_line_parser_top #(
    parameter int MAX_LINE_BYTES = ihex_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [7:0] data_byte, [23:8] position,
                                        // [24] line_ok, [32:25] record_type,
                                        // [40:33] byte_count,
                                        // [56:41] load_address,
                                        // [72:57] fill_level, rest zero
    output logic        m_axis_tuser    // [0] kind
);

    logic              w_front_valid;
    ihex_pkg::t_tok    w_front_tok;
    logic              w_q_push_ready;
    logic              w_q_valid;
    ihex_pkg::t_tok    w_q_tok;
    ihex_pkg::t_q_stat w_q_stat;
    logic              w_pop;
    logic              w_kind;
    logic [7:0]        w_data_byte;
    logic [15:0]       w_position;
    logic              w_line_ok;
    logic [7:0]        w_record_type;
    logic [7:0]        w_byte_count;
    logic [15:0]       w_load_address;
    logic [15:0]       w_fill_level;

    // Character classification.
    ihex_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_char      (s_axis_tdata),
        .o_ready     (s_axis_tready),
        .o_tok_valid (w_front_valid),
        .o_tok       (w_front_tok),
        .i_tok_ready (w_q_push_ready)
    );

    // Token queue between the two halves.
    ihex_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_front_valid),
        .i_tok        (w_front_tok),
        .o_push_ready (w_q_push_ready),
        .i_pop        (w_pop),
        .o_valid      (w_q_valid),
        .o_tok        (w_q_tok),
        .o_stat       (w_q_stat)
    );

    // Record decode and result register.
    ihex_back #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tok_valid    (w_q_valid),
        .i_tok          (w_q_tok),
        .o_pop          (w_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_kind         (w_kind),
        .o_data_byte    (w_data_byte),
        .o_position     (w_position),
        .o_line_ok      (w_line_ok),
        .o_record_type  (w_record_type),
        .o_byte_count   (w_byte_count),
        .o_load_address (w_load_address),
        .o_fill_level   (w_fill_level)
    );

    // Output packing.
    assign m_axis_tuser = w_kind;
    assign m_axis_tdata = {7'd0, w_fill_level, w_load_address, w_byte_count,
                           w_record_type, w_line_ok, w_position, w_data_byte};

    // A payload byte never carries record-end fields.
    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ihex_pkg::KIND_DATA) |->
        (m_axis_tdata[72:24] == '0))
        else $error("payload byte carries record-end fields");

    // The queue never holds more tokens than its depth.
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.count <= ihex_pkg::Q_CNT_W'(ihex_pkg::Q_DEPTH))
        else $error("token queue overflow");

    // The back end pops only when a token is present.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty token queue");

    // With no token to decode, a drained output stays empty.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_q_valid && (!m_axis_tvalid || m_axis_tready)) |=> !m_axis_tvalid)
        else $error("result appeared without a token");

    // A full queue holds back the front stage.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_stat.full && w_front_valid) |-> !s_axis_tready)
        else $error("input accepted while the queue is full");

endmodule
